[design/htls_pkg.sv]
// ----------------------------------------------------------------------------
// htls_pkg - shared types and constants of the HT-LTF LS channel estimator
// Sizes, training sign tables, bin decoding and the stage-to-stage structs.
// ----------------------------------------------------------------------------
package htls_pkg;

    localparam int RX_CHAINS        = 4;
    localparam int FFT_SIZE         = 64;
    localparam int USED_SUBCARRIERS = 56;
    localparam int STREAMS          = 4;

    localparam int CHAIN_W  = 2;
    localparam int LTF_W    = 2;
    localparam int BIN_W    = $clog2(FFT_SIZE);
    localparam int SUB_W    = 6;
    localparam int STRM_W   = 2;
    localparam int SMP_W    = 16;
    localparam int ACC_W    = 36;
    localparam int PROD_W   = 2 * SMP_W;
    localparam int ROWS     = RX_CHAINS * USED_SUBCARRIERS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

    // packed field widths of the two streams, padded to whole bytes
    localparam int IN_BITS  = CHAIN_W + LTF_W + BIN_W + 2 * SMP_W;
    localparam int OUT_BITS = CHAIN_W + SUB_W + STRM_W + 2 * SMP_W;
    localparam int TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // 1/sqrt(56) in Q0.16
    localparam logic signed [SMP_W-1:0] SCALE_Q016 = 16'sd8758;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STS_COUNT = 2'd0,
        CFG_LTF_LOG2  = 2'd1,
        CFG_MODE      = 2'd2
    } cfg_reg_t;

    // P_HTLTF signs [stream][ltf], 1 = +1
    localparam logic [0:3][0:3] P_POS = {4'b1011, 4'b1101, 4'b1110, 4'b0111};

    // L-sequence signs for the used subcarriers in training order, 1 = +1
    localparam logic [0:USED_SUBCARRIERS-1] TRAIN_POS =
        56'b1001101010000011001010111100_1111001101011111100110101111;

    typedef struct packed {
        logic                     ok;
        logic [SUB_W-1:0]         sub;
    } sub_dec_t;

    // bins 1..28 -> 0..27, bins 36..63 -> 28..55, others unused
    function automatic sub_dec_t bin_to_sub(input logic [BIN_W-1:0] bin);
        sub_dec_t d;
        d.ok  = 1'b0;
        d.sub = '0;
        if (bin >= BIN_W'(1) && bin <= BIN_W'(28)) begin
            d.ok  = 1'b1;
            d.sub = SUB_W'(bin - BIN_W'(1));
        end else if (bin >= BIN_W'(36)) begin
            d.ok  = 1'b1;
            d.sub = SUB_W'(bin - BIN_W'(8));
        end
        return d;
    endfunction

    // scaled, training-signed bin heading into the accumulator stage
    typedef struct packed {
        logic                     vld;
        logic                     emit;
        logic [CHAIN_W-1:0]       chain;
        logic [SUB_W-1:0]         sub;
        logic [ROW_W-1:0]         row;
        logic [LTF_W-1:0]         ltf;
        logic [STREAMS-1:0]       wmask;
        logic signed [SMP_W-1:0]  y_re;
        logic signed [SMP_W-1:0]  y_im;
    } htls_bin_t;

    // updated sums leaving the accumulator stage
    typedef struct packed {
        logic                           vld;
        logic                           emit;
        logic [CHAIN_W-1:0]             chain;
        logic [SUB_W-1:0]               sub;
        logic [STREAMS-1:0][ACC_W-1:0]  acc_re;
        logic [STREAMS-1:0][ACC_W-1:0]  acc_im;
    } htls_sum_t;

endpackage

[design/htls_accum.sv]
// ----------------------------------------------------------------------------
// htls_accum - accumulator store and read-modify-write stage
// One bank per stream, one row per (chain, subcarrier); bypass from the
// write stage covers the read-before-write gap between neighbors.
// ----------------------------------------------------------------------------
module htls_accum (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  htls_pkg::htls_bin_t bin_in,
    output htls_pkg::htls_sum_t sum_out
);
    import htls_pkg::*;

    logic [2*ACC_W-1:0] acc_mem [STREAMS][ROWS];
    logic [2*ACC_W-1:0] rd_reg  [STREAMS];

    htls_bin_t s3_reg;

    logic                          s4_vld_reg;
    logic                          s4_emit_reg;
    logic [CHAIN_W-1:0]            s4_chain_reg;
    logic [SUB_W-1:0]              s4_sub_reg;
    logic [ROW_W-1:0]              s4_row_reg;
    logic [STREAMS-1:0]            s4_wmask_reg;
    logic [STREAMS-1:0][ACC_W-1:0] s4_re_reg;
    logic [STREAMS-1:0][ACC_W-1:0] s4_im_reg;

    logic [STREAMS-1:0][ACC_W-1:0] sum_re_next;
    logic [STREAMS-1:0][ACC_W-1:0] sum_im_next;

    // add stage: old + P-signed y, or the P-signed y alone on the first LTF
    always_comb begin
        logic [ACC_W-1:0] old_re;
        logic [ACC_W-1:0] old_im;
        logic [ACC_W-1:0] y_re;
        logic [ACC_W-1:0] y_im;
        logic [ACC_W-1:0] v_re;
        logic [ACC_W-1:0] v_im;
        y_re = ACC_W'($signed(s3_reg.y_re));
        y_im = ACC_W'($signed(s3_reg.y_im));
        for (int s = 0; s < STREAMS; s++) begin
            if (s4_vld_reg && s4_wmask_reg[s] && (s4_row_reg == s3_reg.row)) begin
                old_re = s4_re_reg[s];
                old_im = s4_im_reg[s];
            end else begin
                old_re = rd_reg[s][ACC_W-1:0];
                old_im = rd_reg[s][2*ACC_W-1:ACC_W];
            end
            v_re = P_POS[s][s3_reg.ltf] ? y_re : -y_re;
            v_im = P_POS[s][s3_reg.ltf] ? y_im : -y_im;
            if (s3_reg.ltf == '0) begin
                sum_re_next[s] = v_re;
                sum_im_next[s] = v_im;
            end else begin
                sum_re_next[s] = old_re + v_re;
                sum_im_next[s] = old_im + v_im;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_reg.vld <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_reg.vld <= bin_in.vld;
            s4_vld_reg <= s3_reg.vld;
        end
        if (adv) begin
            s3_reg.emit  <= bin_in.emit;
            s3_reg.chain <= bin_in.chain;
            s3_reg.sub   <= bin_in.sub;
            s3_reg.row   <= bin_in.row;
            s3_reg.ltf   <= bin_in.ltf;
            s3_reg.wmask <= bin_in.wmask;
            s3_reg.y_re  <= bin_in.y_re;
            s3_reg.y_im  <= bin_in.y_im;
            s4_emit_reg  <= s3_reg.emit;
            s4_chain_reg <= s3_reg.chain;
            s4_sub_reg   <= s3_reg.sub;
            s4_row_reg   <= s3_reg.row;
            s4_wmask_reg <= s3_reg.wmask;
            s4_re_reg    <= sum_re_next;
            s4_im_reg    <= sum_im_next;
        end
    end

    // banks: read for the incoming bin, write back the finished sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < STREAMS; s++) begin
                rd_reg[s] <= acc_mem[s][bin_in.row];
                if (s3_reg.vld && s3_reg.wmask[s]) begin
                    acc_mem[s][s3_reg.row] <= {sum_im_next[s], sum_re_next[s]};
                end
            end
        end
    end

    assign sum_out.vld    = s4_vld_reg;
    assign sum_out.emit   = s4_emit_reg;
    assign sum_out.chain  = s4_chain_reg;
    assign sum_out.sub    = s4_sub_reg;
    assign sum_out.acc_re = s4_re_reg;
    assign sum_out.acc_im = s4_im_reg;

endmodule

[design/ht_ltf_ls_channel_estimator.sv]
// ----------------------------------------------------------------------------
// ht_ltf_ls_channel_estimator - HT-LTF least-squares channel estimator
// Accumulates P-signed training bins per chain/subcarrier/stream and emits
// one Q1.15 estimate per space-time stream on the last HT-LTF.
// ----------------------------------------------------------------------------
// Feed post-FFT bins tagged with chain, HT-LTF number and bin index, one per
// cycle. Bins 0 and 29..35, bins of an LTF beyond the configured count and
// every bin in mode 1 are dropped. A kept bin of an earlier LTF gives no
// output; a bin of the last LTF gives sts_count result transfers in a row
// (stream 0 up, tlast on the highest stream). s_tready drops only while a
// further such bin waits in the sum stage for the serializer to finish its
// run. The accumulator store (four banks of 224 x 72 bits) has no reset and
// no clearing pass: LTF 0 overwrites a row, so every run must start with
// LTF 0. Write the configuration port only while the block is empty.
module ht_ltf_ls_channel_estimator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input bins
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_chain, ltf_number, bin_index, sample_re, sample_im (LSB first)
    input  logic [htls_pkg::TDATA_W-1:0]     s_tdata,
    // channel estimates
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_rx_chain, subcarrier, stream, coef_re, coef_im (LSB first)
    output logic [htls_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [htls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htls_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import htls_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_DATA_W-1:0] sts_reg;
    logic [1:0]            lg_reg;
    logic                  mode_reg;

    logic [1:0]            lg_eff;
    logic [LTF_W-1:0]      last_ltf;
    logic [2:0]            nsts_eff;
    logic [STREAMS-1:0]    wmask;

    // ---------------- pipeline ----------------
    logic                  pipe_en;
    sub_dec_t              in_dec;
    logic                  in_keep;
    logic [8:0]            in_row_full;

    logic                  s1_vld_reg;
    logic [CHAIN_W-1:0]    s1_chain_reg;
    logic [LTF_W-1:0]      s1_ltf_reg;
    logic [SUB_W-1:0]      s1_sub_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic signed [SMP_W-1:0] s1_re_reg;
    logic signed [SMP_W-1:0] s1_im_reg;

    logic                  s2_vld_reg;
    logic [CHAIN_W-1:0]    s2_chain_reg;
    logic [LTF_W-1:0]      s2_ltf_reg;
    logic [SUB_W-1:0]      s2_sub_reg;
    logic [ROW_W-1:0]      s2_row_reg;
    logic signed [PROD_W-1:0] s2_prod_re_reg;
    logic signed [PROD_W-1:0] s2_prod_im_reg;

    logic signed [PROD_W-1:0] rnd_re;
    logic signed [PROD_W-1:0] rnd_im;
    logic signed [SMP_W-1:0]  y_re;
    logic signed [SMP_W-1:0]  y_im;

    htls_bin_t             s2_bin;
    htls_sum_t             s4_sum;

    logic                  s5_vld_reg;
    logic [STRM_W-1:0]     s5_beat_reg;
    logic [STRM_W-1:0]     s5_lastidx_reg;
    logic [CHAIN_W-1:0]    s5_chain_reg;
    logic [SUB_W-1:0]      s5_sub_reg;
    logic [SMP_W-1:0]      s5_re_reg [STREAMS];
    logic [SMP_W-1:0]      s5_im_reg [STREAMS];
    logic                  s5_last;
    logic                  s5_load;

    // divide by the LTF count: add half, arithmetic shift, clip to Q1.15
    function automatic logic [SMP_W-1:0] round_sat(input logic [ACC_W-1:0] acc,
                                                   input logic [1:0] lg);
        logic signed [ACC_W:0] sum;
        logic signed [ACC_W:0] half;
        logic signed [ACC_W:0] shr;
        logic [SMP_W-1:0]      res;
        case (lg)
            2'd1:    half = (ACC_W+1)'(1);
            2'd2:    half = (ACC_W+1)'(2);
            default: half = '0;
        endcase
        sum = $signed({acc[ACC_W-1], acc}) + half;
        shr = sum >>> lg;
        if (shr > (ACC_W+1)'(32767)) begin
            res = 16'h7FFF;
        end else if (shr < -(ACC_W+1)'(32768)) begin
            res = 16'h8000;
        end else begin
            res = shr[SMP_W-1:0];
        end
        return res;
    endfunction

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sts_reg  <= CFG_DATA_W'(1);
            lg_reg   <= 2'd0;
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STS_COUNT: sts_reg  <= cfg_data;
                CFG_LTF_LOG2:  lg_reg   <= cfg_data[1:0];
                CFG_MODE:      mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // out-of-range settings clamp: log2 of 3 acts as 2, stream count to 1..STREAMS
    assign lg_eff = (lg_reg == 2'd3) ? 2'd2 : lg_reg;

    always_comb begin
        case (lg_eff)
            2'd1:    last_ltf = LTF_W'(1);
            2'd2:    last_ltf = LTF_W'(3);
            default: last_ltf = LTF_W'(0);
        endcase
        if (sts_reg == '0) begin
            nsts_eff = 3'd1;
        end else if (sts_reg > 3'(STREAMS)) begin
            nsts_eff = 3'(STREAMS);
        end else begin
            nsts_eff = sts_reg;
        end
        for (int s = 0; s < STREAMS; s++) begin
            wmask[s] = (3'(s) < nsts_eff);
        end
    end

    // ---------------- flow control ----------------
    // Whole pipe moves in lockstep; it only waits when an emitting item sits
    // in the sum stage and the output serializer cannot take it.
    assign s5_last  = (s5_beat_reg == s5_lastidx_reg);
    assign pipe_en  = !(s4_sum.vld && s4_sum.emit) || !s5_vld_reg || (m_tready && s5_last);
    assign s_tready = pipe_en;

    // ---------------- stage 1: decode and capture ----------------
    assign in_dec      = bin_to_sub(s_tdata[9:4]);
    assign in_row_full = 9'(s_tdata[1:0]) * 9'(USED_SUBCARRIERS) + 9'(in_dec.sub);
    assign in_keep     = !mode_reg && in_dec.ok
                         && ({2'b00, s_tdata[1:0]} < 4'(RX_CHAINS))
                         && (s_tdata[3:2] <= last_ltf);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg <= s_tvalid && in_keep;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_chain_reg   <= s_tdata[1:0];
            s1_ltf_reg     <= s_tdata[3:2];
            s1_sub_reg     <= in_dec.sub;
            s1_row_reg     <= in_row_full[ROW_W-1:0];
            s1_re_reg      <= s_tdata[25:10];
            s1_im_reg      <= s_tdata[41:26];
            // stage 2: 16x16 scale by 1/sqrt(56)
            s2_chain_reg   <= s1_chain_reg;
            s2_ltf_reg     <= s1_ltf_reg;
            s2_sub_reg     <= s1_sub_reg;
            s2_row_reg     <= s1_row_reg;
            s2_prod_re_reg <= s1_re_reg * SCALE_Q016;
            s2_prod_im_reg <= s1_im_reg * SCALE_Q016;
        end
    end

    // round half up, drop 16 fraction bits, apply the training sign
    assign rnd_re = s2_prod_re_reg + PROD_W'(32768);
    assign rnd_im = s2_prod_im_reg + PROD_W'(32768);
    assign y_re   = TRAIN_POS[s2_sub_reg] ? rnd_re[PROD_W-1:SMP_W] : -rnd_re[PROD_W-1:SMP_W];
    assign y_im   = TRAIN_POS[s2_sub_reg] ? rnd_im[PROD_W-1:SMP_W] : -rnd_im[PROD_W-1:SMP_W];

    always_comb begin
        s2_bin.vld   = s2_vld_reg;
        s2_bin.emit  = (s2_ltf_reg == last_ltf);
        s2_bin.chain = s2_chain_reg;
        s2_bin.sub   = s2_sub_reg;
        s2_bin.row   = s2_row_reg;
        s2_bin.ltf   = s2_ltf_reg;
        s2_bin.wmask = wmask;
        s2_bin.y_re  = y_re;
        s2_bin.y_im  = y_im;
    end

    // ---------------- stages 3-4: accumulate ----------------
    htls_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (pipe_en),
        .bin_in  (s2_bin),
        .sum_out (s4_sum)
    );

    // ---------------- stage 5: scale down and serialize streams ----------------
    assign s5_load = pipe_en && s4_sum.vld && s4_sum.emit;

    // a load only happens when the serializer is idle or finishing its run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg  <= 1'b0;
            s5_beat_reg <= '0;
        end else if (s5_load) begin
            s5_vld_reg  <= 1'b1;
            s5_beat_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            if (s5_last) begin
                s5_vld_reg <= 1'b0;
            end else begin
                s5_beat_reg <= s5_beat_reg + STRM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_load) begin
            s5_lastidx_reg <= STRM_W'(nsts_eff - 3'd1);
            s5_chain_reg   <= s4_sum.chain;
            s5_sub_reg     <= s4_sum.sub;
            for (int s = 0; s < STREAMS; s++) begin
                s5_re_reg[s] <= round_sat(s4_sum.acc_re[s], lg_eff);
                s5_im_reg[s] <= round_sat(s4_sum.acc_im[s], lg_eff);
            end
        end
    end

    assign m_tvalid = s5_vld_reg;
    assign m_tlast  = s5_last;
    assign m_tdata  = {(M_TDATA_W - OUT_BITS)'(0),
                       s5_im_reg[s5_beat_reg], s5_re_reg[s5_beat_reg],
                       s5_beat_reg, s5_sub_reg, s5_chain_reg};

    // ---------------- checks ----------------
    a_beat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_vld_reg |-> (s5_beat_reg <= s5_lastidx_reg))
        else $error("stream counter ran past the configured stream count");

    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || s5_beat_reg == '0))
        else $error("new run does not start at stream 0");

    a_run_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && s5_beat_reg == $past(s5_beat_reg) + STRM_W'(1)
         && $stable(s5_sub_reg) && $stable(s5_chain_reg)))
        else $error("run broken before its last stream");

    a_mode_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg && pipe_en) |=> !s1_vld_reg)
        else $error("bin kept while estimation is off");

endmodule

[bench/tb_ht_ltf_ls_channel_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ht_ltf_ls_channel_estimator - bench for the HT-LTF LS channel estimator
// Streams tagged FFT bins through the estimator, predicts every channel
// coefficient from its own copy of the sums and setup, and checks each
// result transfer in order. Directed corners first, then random frames.
// ----------------------------------------------------------------------------
module tb_ht_ltf_ls_channel_estimator;

    import htls_pkg::*;

    // training signs per used subcarrier and P_HTLTF signs [stream][ltf]
    localparam bit [0:55] TRAIN_SIGN =
        56'b1001101010000011001010111100_1111001101011111100110101111;
    localparam bit [0:3][0:3] P_SIGN = {4'b1011, 4'b1101, 4'b1110, 4'b0111};
    localparam int Q016_SCALE = 8758;
    localparam int SETTLE_CYCLES = 12;   // outlasts the pipeline

    typedef struct packed {
        logic [1:0]  chain;
        logic [5:0]  sub;
        logic [1:0]  strm;
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } coef_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [TDATA_W-1:0]      s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // bench copy of the estimator state and setup
    logic [35:0] sum_re [0:3][0:55][0:3];
    logic [35:0] sum_im [0:3][0:55][0:3];
    bit          sum_seen [0:3][0:55][0:3];
    logic [2:0]  cur_sts  = 3'd1;
    logic [1:0]  cur_lg   = 2'd0;
    logic        cur_mode = 1'b0;

    coef_t coef_expected_q [$];
    int    err_cnt    = 0;
    int    kept_bins  = 0;
    int    burst_left = 0;
    int    stall_cyc  = 0;

    ht_ltf_ls_channel_estimator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Receiver: cycles through always-ready, random stalls and long stall runs.
    always @(posedge aclk) begin
        stall_cyc <= stall_cyc + 1;
        case ((stall_cyc / 97) % 3)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_tready <= ((stall_cyc % 13) < 4);
            end
        endcase
    end

    // Effective stream and LTF counts after clamping of out-of-range settings.
    function automatic int eff_sts();
        return (cur_sts == 3'd0) ? 1 : ((cur_sts > 3'd4) ? 4 : int'(cur_sts));
    endfunction

    function automatic int eff_lg();
        return (cur_lg > 2'd2) ? 2 : int'(cur_lg);
    endfunction

    // Used-subcarrier position of a bin, -1 for DC, guard and unused bins.
    function automatic int bin_position(input logic [5:0] bin);
        if (bin >= 6'd1 && bin <= 6'd28) return int'(bin) - 1;
        if (bin >= 6'd36) return int'(bin) - 8;
        return -1;
    endfunction

    // Updates the sums for one accepted bin and queues the coefficients it
    // releases on the last LTF. Returns 1 when the bin was kept.
    function automatic int estimate_bin(input logic [1:0] chain, input logic [1:0] ltf,
                                        input logic [5:0] bin,
                                        input logic signed [15:0] re,
                                        input logic signed [15:0] im);
        int     sub;
        int     nsts;
        int     lg;
        longint yr, yi, vr, vi, ar, ai, half, cr, ci;
        logic [35:0] nr, ni;
        coef_t  c;
        sub  = bin_position(bin);
        nsts = eff_sts();
        lg   = eff_lg();
        if (cur_mode || sub < 0 || int'(ltf) >= (1 << lg)) return 0;
        // 1/sqrt(56) scaling, round half up, then training sign
        yr = (longint'(re) * Q016_SCALE + 32768) >>> 16;
        yi = (longint'(im) * Q016_SCALE + 32768) >>> 16;
        if (!TRAIN_SIGN[sub]) begin
            yr = -yr;
            yi = -yi;
        end
        for (int s = 0; s < nsts; s++) begin
            vr = P_SIGN[s][ltf] ? yr : -yr;
            vi = P_SIGN[s][ltf] ? yi : -yi;
            if (ltf == 2'd0) begin
                nr = 36'(vr);
                ni = 36'(vi);
            end else begin
                nr = sum_re[chain][sub][s] + 36'(vr);
                ni = sum_im[chain][sub][s] + 36'(vi);
            end
            sum_re[chain][sub][s]   = nr;
            sum_im[chain][sub][s]   = ni;
            sum_seen[chain][sub][s] = 1'b1;
            if (int'(ltf) == (1 << lg) - 1) begin
                ar   = longint'($signed(nr));
                ai   = longint'($signed(ni));
                half = (lg > 0) ? (longint'(1) <<< (lg - 1)) : 0;
                cr   = (ar + half) >>> lg;
                ci   = (ai + half) >>> lg;
                cr   = (cr > 32767) ? 32767 : ((cr < -32768) ? -32768 : cr);
                ci   = (ci > 32767) ? 32767 : ((ci < -32768) ? -32768 : ci);
                c.chain = chain;
                c.sub   = 6'(sub);
                c.strm  = 2'(s);
                c.re    = 16'(cr);
                c.im    = 16'(ci);
                c.last  = (s == nsts - 1);
                coef_expected_q.push_back(c);
            end
        end
        return 1;
    endfunction

    // Checks each result transfer against the oldest pending coefficient.
    always @(posedge aclk) begin : coef_check
        coef_t got;
        coef_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.chain = m_tdata[1:0];
            got.sub   = m_tdata[7:2];
            got.strm  = m_tdata[9:8];
            got.re    = m_tdata[25:10];
            got.im    = m_tdata[41:26];
            got.last  = m_tlast;
            if (coef_expected_q.size() == 0) begin
                $display("%0t: unexpected estimate chain=%0d sub=%0d strm=%0d re=%0d im=%0d",
                         $time, got.chain, got.sub, got.strm,
                         $signed(got.re), $signed(got.im));
                err_cnt++;
            end else begin
                want = coef_expected_q.pop_front();
                if (got.chain !== want.chain || got.sub !== want.sub ||
                    got.strm !== want.strm || got.re !== want.re ||
                    got.im !== want.im || got.last !== want.last) begin
                    $display("%0t: estimate mismatch expected chain=%0d sub=%0d strm=%0d re=%0d im=%0d last=%0b",
                             $time, want.chain, want.sub, want.strm,
                             $signed(want.re), $signed(want.im), want.last);
                    $display("%0t:                   actual chain=%0d sub=%0d strm=%0d re=%0d im=%0d last=%0b",
                             $time, got.chain, got.sub, got.strm,
                             $signed(got.re), $signed(got.im), got.last);
                    err_cnt++;
                end
            end
        end
    end

    // Mostly random samples, with the two extremes mixed in now and then.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One bin transfer. The sender runs in bursts of random length, and an idle
    // gap of random length opens each new burst.
    task automatic send_bin(input logic [1:0] chain, input logic [1:0] ltf,
                            input logic [5:0] bin, input logic [15:0] re,
                            input logic [15:0] im);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({im, re, bin, ltf, chain});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        kept_bins += estimate_bin(chain, ltf, bin, re, im);
    endtask

    // Stops sending and lets every pending coefficient drain, plus the
    // pipeline depth for bins that release nothing.
    task automatic drain_estimates();
        int waited;
        waited     = 0;
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (coef_expected_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the caller drops cfg_valid after the last one.
    task automatic write_reg(input cfg_reg_t idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_STS_COUNT: cur_sts  = val;
            CFG_LTF_LOG2:  cur_lg   = val[1:0];
            CFG_MODE:      cur_mode = val[0];
            default: ;
        endcase
    endtask

    // Idle the block, then load a full setup.
    task automatic load_setup(input logic [2:0] sts, input logic [1:0] lg,
                              input logic mode);
        drain_estimates();
        write_reg(CFG_STS_COUNT, sts);
        write_reg(CFG_LTF_LOG2, {1'b0, lg});
        write_reg(CFG_MODE, {2'b0, mode});
        cfg_valid <= 1'b0;
    endtask

    // Reset setup: one stream, one LTF. Band-edge bins on every chain with
    // full-scale and small samples, plus DC, guard bins and an LTF beyond the count.
    task automatic test_default_setup();
        send_bin(2'd0, 2'd0, 6'd1,  16'h7fff, 16'h8000);
        send_bin(2'd1, 2'd0, 6'd63, 16'h8000, 16'h7fff);
        send_bin(2'd2, 2'd0, 6'd28, 16'hffff, 16'h0000);
        send_bin(2'd3, 2'd0, 6'd36, 16'h0001, 16'hffff);
        send_bin(2'd0, 2'd0, 6'd0,  16'h1234, 16'h4321);
        send_bin(2'd1, 2'd0, 6'd29, 16'h7fff, 16'h7fff);
        send_bin(2'd2, 2'd0, 6'd35, 16'h8000, 16'h8000);
        send_bin(2'd3, 2'd1, 6'd5,  16'h5555, 16'haaaa);
    endtask

    // Four streams over four LTFs, then the clamped settings: stream count
    // 0 and 7, LTF exponent 3, and an LTF beyond a count of two.
    task automatic test_stream_ltf_extremes();
        load_setup(3'd4, 2'd2, 1'b0);
        for (int l = 0; l < 4; l++) send_bin(2'd3, 2'(l), 6'd40, 16'hffff, 16'h0000);
        for (int l = 0; l < 4; l++) send_bin(2'd2, 2'(l), 6'd10, 16'h7fff, 16'h7fff);
        load_setup(3'd0, 2'd3, 1'b0);
        for (int l = 0; l < 4; l++) send_bin(2'd1, 2'(l), 6'd20, 16'h8000, 16'h8000);
        load_setup(3'd7, 2'd1, 1'b0);
        send_bin(2'd0, 2'd0, 6'd50, 16'h4000, 16'hc000);
        send_bin(2'd0, 2'd1, 6'd50, 16'h3fff, 16'hbfff);
        send_bin(2'd0, 2'd2, 6'd50, 16'h1111, 16'h2222);
    endtask

    // Mode 1 drops everything and leaves the sums alone.
    task automatic test_mode_off();
        load_setup(3'd2, 2'd0, 1'b1);
        send_bin(2'd0, 2'd0, 6'd10, 16'h7fff, 16'h8000);
        send_bin(2'd3, 2'd0, 6'd63, 16'h0100, 16'h0200);
    endtask

    // Random setups, each in mode 0 with a few well-formed frames (every LTF in order
    // over a random set of chain/bin pairs) and stray bins in between, or in mode 1 with stray bins only.
    task automatic test_random_frames();
        logic [1:0] fr_chain [0:7];
        logic [5:0] fr_bin   [0:7];
        logic [1:0] n_chain, n_ltf;
        logic [5:0] n_bin;
        int         pairs, sub, nsts, nltf;
        bit         fresh;
        while (kept_bins < 215) begin
            if ($urandom_range(0, 6) == 0) begin
                load_setup(3'($urandom), 2'($urandom), 1'b1);
                repeat (6) send_bin(2'($urandom), 2'($urandom), 6'($urandom),
                                    rand_sample(), rand_sample());
            end else begin
                case ($urandom_range(0, 3))
                    0:       load_setup(3'd4, 2'd2, 1'b0);
                    1:       load_setup(3'd1, 2'd0, 1'b0);
                    default: load_setup(3'($urandom), 2'($urandom), 1'b0);
                endcase
                nsts = eff_sts();
                nltf = 1 << eff_lg();
                repeat ($urandom_range(2, 4)) begin
                    pairs = $urandom_range(1, 8);
                    for (int p = 0; p < pairs; p++) begin
                        fr_chain[p] = 2'($urandom);
                        sub         = $urandom_range(0, 55);
                        fr_bin[p]   = 6'((sub < 28) ? sub + 1 : sub + 8);
                    end
                    for (int l = 0; l < nltf; l++) begin
                        for (int p = 0; p < pairs; p++) begin
                            if ($urandom_range(0, 6) == 0) begin
                                n_chain = 2'($urandom);
                                n_ltf   = 2'($urandom);
                                n_bin   = 6'($urandom);
                                sub     = bin_position(n_bin);
                                // never add onto a sum that was never started
                                if (sub >= 0 && n_ltf != 2'd0) begin
                                    fresh = 1'b0;
                                    for (int s = 0; s < nsts; s++)
                                        if (!sum_seen[n_chain][sub][s]) fresh = 1'b1;
                                    if (fresh) n_ltf = 2'd0;
                                end
                                send_bin(n_chain, n_ltf, n_bin, rand_sample(), rand_sample());
                            end
                            send_bin(fr_chain[p], 2'(l), fr_bin[p],
                                     rand_sample(), rand_sample());
                        end
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_setup();
        test_stream_ltf_extremes();
        test_mode_off();
        test_random_frames();

        drain_estimates();
        if (coef_expected_q.size() != 0) begin
            $display("%0t: %0d estimates never arrived", $time, coef_expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
